// ===== hw/rtl/sbh_pkg.sv =====
// sbh_pkg: shared types, constants and round functions for the sha-256 byte hasher
// used by sbh_core and sha256_byte_stream_hasher; no dependencies
package sbh_pkg;

   localparam int WORD_W  = 32;
   localparam int BYTE_W  = 8;
   localparam int BLOCK_W = 512;

   typedef logic [7:0][WORD_W-1:0] chain_type;

   typedef struct packed {
      logic              byte_en;
      logic [BYTE_W-1:0] data;
      logic              start;
      logic              reinit;
   } ctl_type;

   localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;
   localparam logic [5:0]        POS_LAST = 6'h3F;
   localparam logic [5:0]        POS_LEN  = 6'd56;

   localparam chain_type INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   function automatic logic [WORD_W-1:0] round_k(input logic [5:0] t);
      logic [WORD_W-1:0] k;
      case (t)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

// ===== hw/rtl/sbh_req_if.sv =====
// sbh_req_if: request channel carrying one command and data byte per transfer
// no dependencies
interface sbh_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] data_byte;

   modport source (output valid, command, data_byte, input ready);
   modport sink   (input valid, command, data_byte, output ready);
endinterface

// ===== hw/rtl/sbh_rsp_if.sv =====
// sbh_rsp_if: response channel carrying one digest word per transfer
// no dependencies
interface sbh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last;

   modport source (output valid, digest_word, word_index, last, input ready);
   modport sink   (input valid, digest_word, word_index, last, output ready);
endinterface

// ===== hw/rtl/sbh_core.sv =====
// sbh_core: block shift register, message schedule and one-round-per-cycle compression
// depends on sbh_pkg
module sbh_core
   import sbh_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  ctl_type   ctl,
   output logic      done,
   output chain_type chain
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_FOLD  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [5:0]         round_ff, round_in;
   chain_type          chain_ff, chain_in;
   chain_type          work_ff, work_in;
   logic [BLOCK_W-1:0] block_ff, block_in;

   logic [WORD_W-1:0] w_cur, w_1, w_9, w_14, sched_new, t1, t2;
   logic [WORD_W-1:0] a, b, c, d, e, f, g, h;

   assign a = work_ff[0];
   assign b = work_ff[1];
   assign c = work_ff[2];
   assign d = work_ff[3];
   assign e = work_ff[4];
   assign f = work_ff[5];
   assign g = work_ff[6];
   assign h = work_ff[7];

   // schedule taps on the block shift line, word 0 at the top
   assign w_cur = block_ff[511:480];
   assign w_1   = block_ff[479:448];
   assign w_9   = block_ff[223:192];
   assign w_14  = block_ff[63:32];

   assign sched_new = small_sigma1(w_14) + w_9 + small_sigma0(w_1) + w_cur;
   assign t1 = h + big_sigma1(e) + ((e & f) ^ (~e & g)) + round_k(round_ff) + w_cur;
   assign t2 = big_sigma0(a) + ((a & b) ^ (a & c) ^ (b & c));

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      chain_in = chain_ff;
      work_in  = work_ff;
      block_in = block_ff;
      if (ctl.byte_en) begin
         block_in = {block_ff[BLOCK_W-BYTE_W-1:0], ctl.data};
      end
      if (ctl.reinit) begin
         chain_in = INIT_HASH;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               work_in  = chain_ff;
               round_in = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            block_in = {block_ff[BLOCK_W-WORD_W-1:0], sched_new};
            work_in  = {g, f, e, d + t1, c, b, a, t1 + t2};
            round_in = round_ff + 6'd1;
            if (round_ff == POS_LAST) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
         chain_ff <= INIT_HASH;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         chain_ff <= chain_in;
      end
      work_ff  <= work_in;
      block_ff <= block_in;
   end

   assign done  = (state_ff == ST_FOLD);
   assign chain = chain_ff;

endmodule

// ===== hw/rtl/sha256_byte_stream_hasher.sv =====
// sha256_byte_stream_hasher: byte absorb, padding sequencer and digest emit
// absorb transfer: one data byte; the 64th byte of a block starts a compression
// finish: one pad byte per cycle up to the block end, then one or two compressions,
// then eight digest words, one per rsp transfer
// compression runs one round per cycle on the shared round unit in sbh_core
// synchronous reset loads the initial hash and clears the byte count
module sha256_byte_stream_hasher
   import sbh_pkg::*;
(
   input logic       clock,
   input logic       reset,
   sbh_req_if.sink   req_if,
   sbh_rsp_if.source rsp_if
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PAD  = 2'd1;
   localparam logic [1:0] ST_HASH = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [5:0]  pos_ff, pos_in;
   logic [63:0] count_ff, count_in;
   logic        mark_ff, mark_in;
   logic        extra_ff, extra_in;
   logic        final_ff, final_in;
   logic        padding_ff, padding_in;
   logic [2:0]  index_ff, index_in;

   ctl_type    ctl;
   logic       done;
   chain_type  chain;

   logic        req_xfer, rsp_xfer;
   logic [63:0] bit_len;
   logic [2:0]  len_sel;
   logic [7:0]  pad_byte;

   sbh_core u_core (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .done  (done),
      .chain (chain)
   );

   assign req_xfer = req_if.valid & req_if.ready;
   assign rsp_xfer = rsp_if.valid & rsp_if.ready;
   assign bit_len  = {count_ff[60:0], 3'b000};
   assign len_sel  = ~pos_ff[2:0];

   always_comb begin
      if (mark_ff) begin
         pad_byte = PAD_MARK;
      end else if (pos_ff >= POS_LEN && !extra_ff) begin
         pad_byte = bit_len[{len_sel, 3'b000} +: 8];
      end else begin
         pad_byte = '0;
      end
   end

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      mark_in    = mark_ff;
      extra_in   = extra_ff;
      final_in   = final_ff;
      padding_in = padding_ff;
      index_in   = index_ff;
      ctl        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (!req_if.command) begin
                  ctl.byte_en = 1'b1;
                  ctl.data    = req_if.data_byte;
                  pos_in      = pos_ff + 6'd1;
                  count_in    = count_ff + 64'd1;
                  if (pos_ff == POS_LAST) begin
                     ctl.start = 1'b1;
                     final_in  = 1'b0;
                     state_in  = ST_HASH;
                  end
               end else begin
                  mark_in    = 1'b1;
                  extra_in   = 1'b0;
                  padding_in = 1'b1;
                  state_in   = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            ctl.byte_en = 1'b1;
            ctl.data    = pad_byte;
            pos_in      = pos_ff + 6'd1;
            mark_in     = 1'b0;
            if (mark_ff && pos_ff >= POS_LEN) begin
               extra_in = 1'b1;
            end
            if (pos_ff == POS_LAST) begin
               ctl.start = 1'b1;
               final_in  = !mark_ff && !extra_ff;
               state_in  = ST_HASH;
            end
         end
         ST_HASH: begin
            if (done) begin
               extra_in = 1'b0;
               if (final_ff) begin
                  index_in = '0;
                  state_in = ST_EMIT;
               end else if (padding_ff) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_xfer) begin
               index_in = index_ff + 3'd1;
               if (index_ff == 3'd7) begin
                  ctl.reinit = 1'b1;
                  count_in   = '0;
                  pos_in     = '0;
                  padding_in = 1'b0;
                  final_in   = 1'b0;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pos_ff     <= '0;
         count_ff   <= '0;
         mark_ff    <= 1'b0;
         extra_ff   <= 1'b0;
         final_ff   <= 1'b0;
         padding_ff <= 1'b0;
         index_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         count_ff   <= count_in;
         mark_ff    <= mark_in;
         extra_ff   <= extra_in;
         final_ff   <= final_in;
         padding_ff <= padding_in;
         index_ff   <= index_in;
      end
   end

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid       = (state_ff == ST_EMIT);
   assign rsp_if.digest_word = chain[index_ff];
   assign rsp_if.word_index  = index_ff;
   assign rsp_if.last        = (index_ff == 3'd7);

endmodule

// ===== hw/rtl/sbh_checker.sv =====
// sbh_checker: port-level checks on the digest stream of the byte hasher
// bound to sha256_byte_stream_hasher; no package dependency
module sbh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last
);

   // stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word)
         && $stable(rsp_word_index))
      else $error("stalled digest word changed");

   // no request taken while a digest is out
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready during digest output");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_word_index == 3'd7)))
      else $error("last flag does not match word index");

   // words follow back to back in index order
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid
         && rsp_word_index == $past(rsp_word_index) + 3'd1)
      else $error("digest word index out of order");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid && req_ready)
      else $error("not ready for a new message after last word");

endmodule

bind sha256_byte_stream_hasher sbh_checker u_sbh_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_digest_word (rsp_if.digest_word),
   .rsp_word_index  (rsp_if.word_index),
   .rsp_last        (rsp_if.last)
);
